[src/hjsc_pkg.sv]
// hjsc_pkg: types, constants and jamo tables for the hangul syllable composer
// used by hjsc_core, hjsc_out_fifo and hangul_jamo_syllable_composer_unit
// no dependencies
package hjsc_pkg;

  localparam logic [15:0] BACKSPACE  = 16'h0008;
  localparam logic [15:0] CONS_BASE  = 16'h3130;
  localparam logic [15:0] VOW_BASE   = 16'h314E;
  localparam logic [15:0] CONS_FIRST = 16'h3131;
  localparam logic [15:0] CONS_LAST  = 16'h314E;
  localparam logic [15:0] VOW_FIRST  = 16'h314F;
  localparam logic [15:0] VOW_LAST   = 16'h3163;
  localparam logic [15:0] SYL_BASE   = 16'hAC00;
  localparam logic [15:0] BAD_IDX    = 16'hFFFF;
  localparam logic [15:0] SYL_STRIDE = 16'd588;
  localparam logic [15:0] FIN_COUNT  = 16'd28;
  // consonants that never sit in the final position
  localparam logic [15:0] CONS_DD    = 16'h3138;
  localparam logic [15:0] CONS_BB    = 16'h3143;
  localparam logic [15:0] CONS_JJ    = 16'h3149;

  typedef logic [4:0] jamo_t;

  typedef struct packed {
    logic [15:0] out_char;
    logic        last;
  } beat_t;

  typedef struct packed {
    logic [1:0] n;
    beat_t      b0;
    beat_t      b1;
  } res_t;

  // compound consonant index from two consonant indices, 0 if they do not join
  function automatic jamo_t cons_pair(input jamo_t a, input jamo_t b);
    jamo_t c;
    c = 5'd0;
    case (a)
      5'd1:  c = (b == 5'd21) ? 5'd3 : 5'd0;
      5'd4: begin
        if (b == 5'd24) c = 5'd5;
        else if (b == 5'd30) c = 5'd6;
      end
      5'd9: begin
        case (b)
          5'd1:    c = 5'd10;
          5'd17:   c = 5'd11;
          5'd18:   c = 5'd12;
          5'd21:   c = 5'd13;
          5'd28:   c = 5'd14;
          5'd29:   c = 5'd15;
          5'd30:   c = 5'd16;
          default: c = 5'd0;
        endcase
      end
      5'd18: c = (b == 5'd21) ? 5'd20 : 5'd0;
      default: c = 5'd0;
    endcase
    return c;
  endfunction

  // compound vowel index from two vowel indices, 0 if they do not join
  function automatic jamo_t vow_pair(input jamo_t a, input jamo_t b);
    jamo_t c;
    c = 5'd0;
    case (a)
      5'd9: begin
        if (b == 5'd1) c = 5'd10;
        else if (b == 5'd2) c = 5'd11;
        else if (b == 5'd21) c = 5'd12;
      end
      5'd14: begin
        if (b == 5'd5) c = 5'd15;
        else if (b == 5'd6) c = 5'd16;
        else if (b == 5'd21) c = 5'd17;
      end
      5'd19: c = (b == 5'd21) ? 5'd20 : 5'd0;
      default: c = 5'd0;
    endcase
    return c;
  endfunction

  function automatic logic cons_can_join(input jamo_t a, input jamo_t b);
    return (a == 5'd0) || (b == 5'd0) || (cons_pair(a, b) != 5'd0);
  endfunction

  function automatic logic vow_can_join(input jamo_t a, input jamo_t b);
    return (a == 5'd0) || (b == 5'd0) || (vow_pair(a, b) != 5'd0);
  endfunction

  function automatic jamo_t cons_join(input jamo_t a, input jamo_t b);
    jamo_t c;
    c = cons_pair(a, b);
    if (a == 5'd0) return b;
    if (b == 5'd0) return a;
    return (c != 5'd0) ? c : a;
  endfunction

  function automatic jamo_t vow_join(input jamo_t a, input jamo_t b);
    jamo_t c;
    c = vow_pair(a, b);
    if (a == 5'd0) return b;
    if (b == 5'd0) return a;
    return (c != 5'd0) ? c : a;
  endfunction

  // initial position index, compound consonants give BAD_IDX
  function automatic logic [15:0] init_index(input jamo_t i);
    logic [15:0] r;
    case (i) inside
      5'd1:            r = 16'd0;
      5'd2:            r = 16'd1;
      5'd4:            r = 16'd2;
      [5'd7:5'd9]:     r = {11'd0, i} - 16'd4;
      [5'd17:5'd19]:   r = {11'd0, i} - 16'd11;
      [5'd21:5'd30]:   r = {11'd0, i} - 16'd12;
      default:         r = BAD_IDX;
    endcase
    return r;
  endfunction

  // final index plus one; an invalid final wraps to 0
  function automatic logic [15:0] fin_term(input jamo_t i);
    logic [15:0] r;
    case (i) inside
      [5'd1:5'd7]:     r = {11'd0, i};
      [5'd9:5'd18]:    r = {11'd0, i} - 16'd1;
      [5'd20:5'd24]:   r = {11'd0, i} - 16'd2;
      [5'd26:5'd30]:   r = {11'd0, i} - 16'd3;
      default:         r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] compose(input jamo_t ini, input jamo_t m0, input jamo_t m1,
                                          input jamo_t f0, input jamo_t f1);
    jamo_t       med;
    jamo_t       fin;
    logic [15:0] ini_term;
    logic [15:0] med_term;
    med = vow_join(m0, m1);
    fin = cons_join(f0, f1);
    ini_term = init_index(ini) * SYL_STRIDE;
    med_term = ({11'd0, med} - 16'd1) * FIN_COUNT;
    if (ini == 5'd0 && med == 5'd0) return (fin == 5'd0) ? 16'd0 : CONS_BASE + {11'd0, fin};
    if (ini == 5'd0) return VOW_BASE + {11'd0, med};
    if (med == 5'd0) return CONS_BASE + {11'd0, ini};
    return SYL_BASE + ini_term + med_term + fin_term(fin);
  endfunction

endpackage

[src/hjsc_core.sv]
// hjsc_core: syllable state registers and the two-set composition rules
// depends on hjsc_pkg
module hjsc_core
  import hjsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] code,
  input  logic        fire,
  output res_t        res
);

  jamo_t ini, m0, m1, f0, f1;
  jamo_t ini_next, m0_next, m1_next, f0_next, f1_next;

  logic        is_bs, is_cons, is_vow;
  logic [15:0] cdiff, vdiff;
  jamo_t       cidx, vidx, cf0, cf1;
  logic        can_final, moving;
  logic [15:0] syl;

  assign is_bs   = (code == BACKSPACE);
  assign is_cons = (code >= CONS_FIRST) && (code <= CONS_LAST);
  assign is_vow  = (code >= VOW_FIRST) && (code <= VOW_LAST);
  assign cdiff   = code - CONS_BASE;
  assign vdiff   = code - VOW_BASE;
  assign cidx    = cdiff[4:0];
  assign vidx    = vdiff[4:0];
  assign can_final = (code != CONS_DD) && (code != CONS_BB) && (code != CONS_JJ);

  // a vowel after a final moves the last final over to the next syllable
  assign moving = is_vow && (f0 != 5'd0);
  assign cf1    = (moving && f1 != 5'd0) ? 5'd0 : f1;
  assign cf0    = (moving && f1 == 5'd0) ? 5'd0 : f0;
  assign syl    = compose(ini, m0, m1, cf0, cf1);

  always_comb begin
    ini_next = ini;
    m0_next  = m0;
    m1_next  = m1;
    f0_next  = f0;
    f1_next  = f1;
    res      = '0;
    if (is_bs) begin
      if (f1 != 5'd0) f1_next = 5'd0;
      else if (f0 != 5'd0) f0_next = 5'd0;
      else if (m1 != 5'd0) m1_next = 5'd0;
      else if (m0 != 5'd0) m0_next = 5'd0;
      else if (ini != 5'd0) ini_next = 5'd0;
      else begin
        res.n  = 2'd1;
        res.b0 = '{out_char: BACKSPACE, last: 1'b1};
      end
    end else if (is_cons) begin
      if (ini != 5'd0 && m0 == 5'd0 && cons_can_join(ini, cidx)) begin
        f0_next  = ini;
        f1_next  = cidx;
        ini_next = 5'd0;
      end else if (ini == 5'd0 || m0 == 5'd0 || !can_final || f1 != 5'd0
                   || !cons_can_join(f0, cidx)) begin
        res.n    = 2'd1;
        res.b0   = '{out_char: syl, last: 1'b1};
        ini_next = cidx;
        m0_next  = 5'd0;
        m1_next  = 5'd0;
        f0_next  = 5'd0;
        f1_next  = 5'd0;
      end else if (f0 == 5'd0) begin
        f0_next = cidx;
      end else begin
        f1_next = cidx;
      end
    end else if (is_vow) begin
      if (moving) begin
        res.n    = 2'd1;
        res.b0   = '{out_char: syl, last: 1'b1};
        ini_next = (f1 != 5'd0) ? f1 : f0;
        m0_next  = vidx;
        m1_next  = 5'd0;
        f0_next  = 5'd0;
        f1_next  = 5'd0;
      end else if (m1 != 5'd0 || !vow_can_join(m0, vidx)) begin
        res.n    = 2'd1;
        res.b0   = '{out_char: syl, last: 1'b1};
        ini_next = 5'd0;
        m0_next  = vidx;
        m1_next  = 5'd0;
        f0_next  = 5'd0;
        f1_next  = 5'd0;
      end else if (m0 == 5'd0) begin
        m0_next = vidx;
      end else begin
        m1_next = vidx;
      end
    end else begin
      res.n    = 2'd2;
      res.b0   = '{out_char: syl, last: 1'b0};
      res.b1   = '{out_char: code, last: 1'b1};
      ini_next = 5'd0;
      m0_next  = 5'd0;
      m1_next  = 5'd0;
      f0_next  = 5'd0;
      f1_next  = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ini <= '0;
      m0  <= '0;
      m1  <= '0;
      f0  <= '0;
      f1  <= '0;
    end else if (fire) begin
      ini <= ini_next;
      m0  <= m0_next;
      m1  <= m1_next;
      f0  <= f0_next;
      f1  <= f1_next;
    end
  end

endmodule

[src/hjsc_out_fifo.sv]
// hjsc_out_fifo: two-entry result buffer, takes up to two beats per cycle
// depends on hjsc_pkg
module hjsc_out_fifo
  import hjsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_n,
  input  beat_t      push_b0,
  input  beat_t      push_b1,
  input  logic       out_ready,
  output logic       out_valid,
  output beat_t      out_beat,
  output logic [1:0] room
);

  logic [1:0] cnt, cnt_next, cnt_left;
  beat_t      e0, e1, e0_next, e1_next, s0;
  logic       pop;

  assign out_valid = (cnt != 2'd0);
  assign out_beat  = e0;
  assign pop       = out_valid && out_ready;
  assign cnt_left  = cnt - {1'b0, pop};
  assign room      = 2'd2 - cnt_left;
  assign s0        = pop ? e1 : e0;

  always_comb begin
    cnt_next = cnt_left + push_n;
    e0_next  = s0;
    e1_next  = e1;
    if (cnt_left == 2'd0 && push_n != 2'd0) e0_next = push_b0;
    if (cnt_left == 2'd0 && push_n == 2'd2) e1_next = push_b1;
    else if (cnt_left == 2'd1 && push_n == 2'd1) e1_next = push_b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    e0 <= e0_next;
    e1 <= e1_next;
  end

endmodule

[src/hangul_jamo_syllable_composer_unit.sv]
// hangul_jamo_syllable_composer_unit: input register, composer core and result buffer
// depends on hjsc_pkg, hjsc_core, hjsc_out_fifo
// a beat waits in the input register; its results are then held in the result buffer
// throughput: one beat per cycle when it gives at most one result and m_tready is high;
// a beat that gives two results waits until the two-entry result buffer has room for both
// reset: synchronous rst empties the syllable, the input register and the result buffer
module hangul_jamo_syllable_composer_unit
  import hjsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // letter_code
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_char
  output logic        m_tlast
);

  logic        in_vld, in_vld_next;
  logic [15:0] in_code;
  logic        fire;
  logic [1:0]  room, push_n;
  res_t        res;
  beat_t       head;

  assign fire     = in_vld && (res.n <= room);
  assign s_tready = !in_vld || fire;
  assign push_n   = fire ? res.n : 2'd0;

  always_comb begin
    in_vld_next = in_vld;
    if (s_tvalid && s_tready) in_vld_next = 1'b1;
    else if (fire) in_vld_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= in_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_code <= s_tdata;
  end

  hjsc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .code (in_code),
    .fire (fire),
    .res  (res)
  );

  hjsc_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_b0   (res.b0),
    .push_b1   (res.b1),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_beat  (head),
    .room      (room)
  );

  assign m_tdata = head.out_char;
  assign m_tlast = head.last;

endmodule
